>>> rtl/cai_pkg.sv
// Package for the checked 64-bit ALU: transaction structs, codes and
// shared constants. No dependencies; every other rtl file imports it.
`default_nettype none
package cai_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned NUM_CELLS = DATA_W;

  localparam logic [DATA_W-1:0] MIN_VAL   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MAX_VAL   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MINUS_ONE = {DATA_W{1'b1}};

  typedef enum logic [2:0] {
    FN_LITERAL   = 3'd0,
    FN_NEGATE    = 3'd1,
    FN_ADD       = 3'd2,
    FN_SUBTRACT  = 3'd3,
    FN_MULTIPLY  = 3'd4,
    FN_DIVIDE    = 3'd5,
    FN_REMAINDER = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_REM_ZERO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
  } out_t;

  // Work carried from cell to cell
  typedef struct packed {
    cell_op_t          op;
    logic              is_rem;
    logic              neg;
    status_t           st;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] mb;
  } cell_t;

endpackage
`default_nettype wire

>>> rtl/cai_pre.sv
// Front decode: simple ops, magnitudes and early status for the cell row.
// Depends on cai_pkg.
`default_nettype none
module cai_pre (
  input  cai_pkg::in_t   in_data,
  output cai_pkg::cell_t cell_data
);
  import cai_pkg::*;

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] ma;
  logic [DATA_W-1:0] mb;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] dif;

  assign a   = in_data.operand_a;
  assign b   = in_data.operand_b;
  assign ma  = a[DATA_W-1] ? (~a + 1'b1) : a;
  assign mb  = b[DATA_W-1] ? (~b + 1'b1) : b;
  assign sum = a + b;
  assign dif = a - b;

  always_comb begin
    cell_data        = '0;
    cell_data.op     = OP_PASS;
    cell_data.st     = ST_OK;
    case (in_data.func)
      FN_LITERAL: begin
        cell_data.lo = a;
      end
      FN_NEGATE: begin
        if (a == MIN_VAL) cell_data.st = ST_OVERFLOW;
        else              cell_data.lo = ~a + 1'b1;
      end
      FN_ADD: begin
        if (a[DATA_W-1] == b[DATA_W-1] && sum[DATA_W-1] != a[DATA_W-1])
          cell_data.st = ST_OVERFLOW;
        else
          cell_data.lo = sum;
      end
      FN_SUBTRACT: begin
        if (a[DATA_W-1] != b[DATA_W-1] && dif[DATA_W-1] != a[DATA_W-1])
          cell_data.st = ST_OVERFLOW;
        else
          cell_data.lo = dif;
      end
      FN_MULTIPLY: begin
        cell_data.op  = OP_MUL;
        cell_data.lo  = ma;
        cell_data.mb  = mb;
        cell_data.neg = a[DATA_W-1] ^ b[DATA_W-1];
      end
      FN_DIVIDE, FN_REMAINDER: begin
        if (b == '0) begin
          cell_data.st = (in_data.func == FN_DIVIDE) ? ST_DIV_ZERO : ST_REM_ZERO;
        end else if (a == MIN_VAL && b == MINUS_ONE) begin
          cell_data.st = ST_OVERFLOW;
        end else begin
          cell_data.op     = OP_DIV;
          cell_data.lo     = ma;
          cell_data.mb     = mb;
          cell_data.is_rem = (in_data.func == FN_REMAINDER);
          cell_data.neg    = (in_data.func == FN_REMAINDER) ? a[DATA_W-1]
                                                            : (a[DATA_W-1] ^ b[DATA_W-1]);
        end
      end
      default: begin
        cell_data.st = ST_OVERFLOW;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/cai_cell.sv
// One cell of the row: one shift-add multiply step or one restoring
// divide step per transaction, registered. Depends on cai_pkg.
`default_nettype none
module cai_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  cai_pkg::cell_t in_cell,
  output logic           out_valid,
  output cai_pkg::cell_t out_cell
);
  import cai_pkg::*;

  logic              valid_r;
  cell_t             cell_r;
  cell_t             cell_nxt;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   t;
  logic [DATA_W+1:0] dif;

  assign sum = {1'b0, in_cell.hi} + (in_cell.lo[0] ? {1'b0, in_cell.mb} : '0);
  assign t   = {in_cell.hi, in_cell.lo[DATA_W-1]};
  assign dif = {1'b0, t} - {2'b00, in_cell.mb};

  always_comb begin
    cell_nxt = in_cell;
    case (in_cell.op)
      OP_MUL: begin
        cell_nxt.hi = sum[DATA_W:1];
        cell_nxt.lo = {sum[0], in_cell.lo[DATA_W-1:1]};
      end
      OP_DIV: begin
        if (!dif[DATA_W+1]) begin
          cell_nxt.hi = dif[DATA_W-1:0];
          cell_nxt.lo = {in_cell.lo[DATA_W-2:0], 1'b1};
        end else begin
          cell_nxt.hi = t[DATA_W-1:0];
          cell_nxt.lo = {in_cell.lo[DATA_W-2:0], 1'b0};
        end
      end
      default: begin
        cell_nxt = in_cell;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule
`default_nettype wire

>>> rtl/cai_post.sv
// Back end: product range check, quotient/remainder pick, sign and
// zeroing on error. Depends on cai_pkg.
`default_nettype none
module cai_post (
  input  cai_pkg::cell_t cell_data,
  output cai_pkg::out_t  out_data
);
  import cai_pkg::*;

  logic [DATA_W-1:0] limit;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] sval;
  status_t           st;

  assign limit = cell_data.neg ? MIN_VAL : MAX_VAL;

  always_comb begin
    st  = cell_data.st;
    mag = cell_data.lo;
    case (cell_data.op)
      OP_MUL: begin
        if (cell_data.hi != '0 || cell_data.lo > limit) st = ST_OVERFLOW;
      end
      OP_DIV: begin
        mag = cell_data.is_rem ? cell_data.hi : cell_data.lo;
      end
      default: begin
        mag = cell_data.lo;
      end
    endcase
  end

  assign sval = (cell_data.op != OP_PASS && cell_data.neg) ? (~mag + 1'b1) : mag;

  assign out_data.value  = (st == ST_OK) ? sval : '0;
  assign out_data.status = st;

endmodule
`default_nettype wire

>>> rtl/checked_int64_alu.sv
// Checked signed 64-bit ALU: front decode, a row of 64 step cells, output register.
// Pipeline: decode register, one register per cell, then the output register;
//   a stall holds every stage.
// Throughput: one transaction per cycle while the sink does not stall; the 64-cell
//   row holds one multiply or divide bit-step per cell, so no op waits on another.
// Reset: synchronous active-low rst_n clears every valid bit; data is not reset.
// Depends on cai_pkg, cai_pre, cai_cell, cai_post.
`default_nettype none
module checked_int64_alu (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cai_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cai_pkg::out_t  out_data
);
  import cai_pkg::*;

  logic  adv;
  cell_t pre_cell;
  logic  pre_valid_r;
  cell_t pre_cell_r;
  logic  cv [NUM_CELLS+1];
  cell_t cd [NUM_CELLS+1];
  out_t  post_data;
  logic  out_valid_r;
  out_t  out_data_r;

  // Hold the whole pipe only while a finished result waits on a stalled sink
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  cai_pre u_pre (
    .in_data   (in_data),
    .cell_data (pre_cell)
  );

  // Decode register: ops are classified before entering the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (adv) begin
      pre_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_cell_r <= pre_cell;
    end
  end

  assign cv[0] = pre_valid_r;
  assign cd[0] = pre_cell_r;

  // Each cell advances one bit of the multiply or divide
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cai_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (cv[i]),
      .in_cell   (cd[i]),
      .out_valid (cv[i+1]),
      .out_cell  (cd[i+1])
    );
  end

  cai_post u_post (
    .cell_data (cd[NUM_CELLS]),
    .out_data  (post_data)
  );

  // Output register; holds while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cv[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= post_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/cai_checker.sv
// Port-level checks for checked_int64_alu, bound to the top level.
// Depends on cai_pkg.
`default_nettype none
module cai_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input cai_pkg::out_t out_data
);
  import cai_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.value == '0)
    else $error("nonzero value with error status");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind checked_int64_alu cai_checker u_cai_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

>>> dv/alu_result_checker.sv
// Checker for the checked 64-bit ALU: predicts each result from the accepted
// input transactions and compares it with the result channel. Depends on cai_pkg.
`timescale 1ns / 100ps
`default_nettype none
module alu_result_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  cai_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  cai_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import cai_pkg::*;

  out_t expected_q[$];

  function automatic logic [63:0] abs64(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic out_t alu_predict(in_t t);
    out_t r;
    logic [63:0] a, b, v, ma, mb, lim, q;
    logic neg;
    status_t st;
    a = t.operand_a;
    b = t.operand_b;
    v = '0;
    st = ST_OK;
    case (t.func)
      FN_LITERAL: v = a;
      FN_NEGATE: begin
        if (a == MIN_VAL) st = ST_OVERFLOW;
        else v = 64'd0 - a;
      end
      FN_ADD: begin
        v = a + b;
        if (a[63] == b[63] && v[63] != a[63]) st = ST_OVERFLOW;
      end
      FN_SUBTRACT: begin
        v = a - b;
        if (a[63] != b[63] && v[63] != a[63]) st = ST_OVERFLOW;
      end
      FN_MULTIPLY: begin
        ma = abs64(a);
        mb = abs64(b);
        neg = a[63] ^ b[63];
        lim = neg ? MIN_VAL : MAX_VAL;
        if (ma != 0 && mb > lim / ma) st = ST_OVERFLOW;
        else begin
          q = ma * mb;
          v = neg ? (64'd0 - q) : q;
        end
      end
      FN_DIVIDE, FN_REMAINDER: begin
        if (b == 0) st = (t.func == FN_DIVIDE) ? ST_DIV_ZERO : ST_REM_ZERO;
        else if (a == MIN_VAL && b == MINUS_ONE) st = ST_OVERFLOW;
        else begin
          ma = abs64(a);
          mb = abs64(b);
          if (t.func == FN_DIVIDE) begin
            q = ma / mb;
            v = (a[63] ^ b[63]) ? (64'd0 - q) : q;
          end else begin
            q = ma % mb;
            v = a[63] ? (64'd0 - q) : q;
          end
        end
      end
      default: st = ST_OVERFLOW;
    endcase
    if (st != ST_OK) v = '0;
    r.value = v;
    r.status = st;
    return r;
  endfunction

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && !in_stall) expected_q.push_back(alu_predict(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("unexpected result: %h/%0d", out_data.value,
                                      out_data.status);
      end else begin
        want = expected_q.pop_front();
        if (want.value !== out_data.value || want.status !== out_data.status) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     want.value, want.status, out_data.value, out_data.status);
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench top for checked_int64_alu: drives directed and random operation
// transactions with random gaps and stalls. Depends on cai_pkg, the RTL and
// alu_result_checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import cai_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   stall_mode = 0;
  int unsigned stall_left = 0;

  checked_int64_alu DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  alu_result_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard limit well above the slowest run: 474 transactions, each with random
  // idle gaps on both sides plus the pipeline latency.
  initial begin
    #(20 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: after each accepted result draw a random wait and hold stall
  // for that long; in the quiet stretch never stall at all.
  always @(posedge clk) begin
    int unsigned n;
    if (stall_mode == 0) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      n = $urandom_range(0, 18);
      stall_left <= n;
      out_stall <= (n != 0);
    end
  end

  // Pick an interesting operand: an extreme, a small value, a 32-bit random value widened to 64 bits, or full random.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN_VAL;
      1: return MAX_VAL;
      2: return MINUS_ONE;
      3: return 64'd0;
      4: return 64'd1;
      5: return 64'($signed($urandom_range(0, 40)) - 20);
      6: return {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
      7: return 64'($signed(32'($urandom)));
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Present one transaction, hold it until accepted, then drop valid for
  // the given gap (or keep it high when the gap is zero).
  task automatic send_op(logic [2:0] f, logic [63:0] a, logic [63:0] b, int gap);
    in_data.func <= f;
    in_data.operand_a <= a;
    in_data.operand_b <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic close_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int g;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every function and each special case.
    send_op(FN_LITERAL,   MIN_VAL, MAX_VAL, 0);
    send_op(FN_LITERAL,   MAX_VAL, 64'd0, 0);
    send_op(FN_NEGATE,    MIN_VAL, 64'd0, 0);
    send_op(FN_NEGATE,    MAX_VAL, MINUS_ONE, 0);
    send_op(FN_ADD,       MAX_VAL, 64'd1, 0);
    send_op(FN_ADD,       MIN_VAL, MINUS_ONE, 0);
    send_op(FN_ADD,       MINUS_ONE, 64'd1, 0);
    send_op(FN_SUBTRACT,  MIN_VAL, 64'd1, 0);
    send_op(FN_SUBTRACT,  MAX_VAL, MINUS_ONE, 0);
    send_op(FN_SUBTRACT,  64'd5, 64'd9, 0);
    send_op(FN_MULTIPLY,  MIN_VAL, 64'd1, 0);
    send_op(FN_MULTIPLY,  MIN_VAL, MINUS_ONE, 0);
    send_op(FN_MULTIPLY,  64'h0000_0001_0000_0000, 64'hFFFF_FFFF_8000_0000, 0);
    send_op(FN_MULTIPLY,  64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000, 0);
    send_op(FN_MULTIPLY,  MAX_VAL, MINUS_ONE, 0);
    send_op(FN_DIVIDE,    64'd7, 64'd0, 0);
    send_op(FN_REMAINDER, 64'd7, 64'd0, 0);
    send_op(FN_DIVIDE,    MIN_VAL, MINUS_ONE, 0);
    send_op(FN_REMAINDER, MIN_VAL, MINUS_ONE, 0);
    send_op(FN_DIVIDE,    -64'sd7, 64'd2, 0);
    send_op(FN_REMAINDER, -64'sd7, 64'd2, 0);
    send_op(FN_REMAINDER, 64'd7, -64'sd2, 0);
    send_op(FN_DIVIDE,    MIN_VAL, MIN_VAL, 0);
    send_op(3'd7,         MAX_VAL, MIN_VAL, 1);

    // Pause until every expected result has come back.
    while (pending != 0) @(posedge clk);
    stall_mode <= 1;

    // Random: bursts with no gaps alternate with gapped stretches.
    for (int i = 0; i < 450; i++) begin
      g = ((i / 50) % 3 == 0) ? 0 : $urandom_range(0, 18);
      send_op(3'($urandom_range(0, 7)), pick_operand(), pick_operand(), g);
    end
    close_stream();

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
rtl/cai_pkg.sv
rtl/cai_pre.sv
rtl/cai_cell.sv
rtl/cai_post.sv
rtl/checked_int64_alu.sv
rtl/cai_checker.sv
dv/alu_result_checker.sv
dv/tb_top.sv
